>>> design/tslru_pkg.sv
package tslru_pkg;

    localparam int KEY_W          = 32;
    localparam int CAP_W          = 5;
    localparam int DEF_HOT_DEPTH  = 16;
    localparam int DEF_COLD_DEPTH = 16;
    localparam int MAX_RESULTS    = 32;
    localparam int RES_W          = 6;
    localparam int POS_W          = 4;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HOT_CAP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_CAP = 1'd1;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [1:0] HIT_MISS = 2'd0;
    localparam logic [1:0] HIT_HOT  = 2'd1;
    localparam logic [1:0] HIT_COLD = 2'd2;

    localparam logic LIST_HOT  = 1'b0;
    localparam logic LIST_COLD = 1'b1;

endpackage

>>> design/two_segment_lru_replacement.sv
// Two-segment LRU replacement tracker.
// Input channel (in_valid / in_stall): one word carries an operation and a key.
// An access word searches the hot list, then the cold list, updates the
// lists and returns one response word (hit status and any evicted key).
// A dump word returns one word per stored key, hot list first, at most 32,
// or a single empty word when both lists are empty; the final word has last.
// Output channel (out_valid / out_stall): one registered output word; the
// receiver may stall it for any time, and the block waits with it.
// An access compares stored keys one at a time and moves keys one at a time;
// a dump reads and emits its words one at a time, hot list before cold list.
// Output stalls lengthen both. This comes from the single read port of each
// list memory and the one comparator.
// in_stall is high from acceptance until the last result is in the output
// register, so a new word may enter while that result still waits.
// Configuration (cfg_we, cfg_index, cfg_data): writes set the hot or cold
// capacity and trim a list that is longer than its new capacity.
// Reset empties both lists and sets both capacities to 16.
module two_segment_lru_replacement #(
    parameter int HOT_DEPTH  = tslru_pkg::DEF_HOT_DEPTH,
    parameter int COLD_DEPTH = tslru_pkg::DEF_COLD_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic signed [tslru_pkg::KEY_W-1:0] access_key,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        result_kind,
    output logic [1:0]                        hit_status,
    output logic                              evict_valid,
    output logic signed [tslru_pkg::KEY_W-1:0] evicted_key,
    output logic                              dump_list,
    output logic [tslru_pkg::POS_W-1:0]       dump_position,
    output logic signed [tslru_pkg::KEY_W-1:0] dump_key,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [tslru_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tslru_pkg::CAP_W-1:0]       cfg_data
);
    import tslru_pkg::*;

    localparam int HAW = (HOT_DEPTH > 1) ? $clog2(HOT_DEPTH) : 1;
    localparam int CAW = (COLD_DEPTH > 1) ? $clog2(COLD_DEPTH) : 1;
    localparam int HCW = $clog2(HOT_DEPTH + 1);
    localparam int CCW = $clog2(COLD_DEPTH + 1);
    localparam int IW  = (HCW > CCW) ? HCW : CCW;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_FIND_RD  = 4'd1;
    localparam logic [3:0] ST_FIND_CMP = 4'd2;
    localparam logic [3:0] ST_SHL_RD   = 4'd3;
    localparam logic [3:0] ST_SHL_WR   = 4'd4;
    localparam logic [3:0] ST_POST     = 4'd5;
    localparam logic [3:0] ST_TAIL_RD  = 4'd6;
    localparam logic [3:0] ST_TAIL_GET = 4'd7;
    localparam logic [3:0] ST_DEMOTE   = 4'd8;
    localparam logic [3:0] ST_MISS     = 4'd9;
    localparam logic [3:0] ST_SHR_RD   = 4'd10;
    localparam logic [3:0] ST_SHR_WR   = 4'd11;
    localparam logic [3:0] ST_RESP     = 4'd12;
    localparam logic [3:0] ST_EMPTY    = 4'd13;
    localparam logic [3:0] ST_DUMP_RD  = 4'd14;
    localparam logic [3:0] ST_DUMP_OUT = 4'd15;

    localparam logic PH_DONE   = 1'b0;
    localparam logic PH_DEMOTE = 1'b1;

    logic [3:0]       state_reg, state_next;
    logic             sel_reg, sel_next;
    logic             phase_reg, phase_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] newkey_reg, newkey_next;
    logic [KEY_W-1:0] aux_reg, aux_next;
    logic [1:0]       hit_reg, hit_next;
    logic             ev_reg, ev_next;
    logic [HCW-1:0]   hot_count_reg, hot_count_next;
    logic [CCW-1:0]   cold_count_reg, cold_count_next;
    logic [CAP_W-1:0] hot_cap_reg, hot_cap_next;
    logic [CAP_W-1:0] cold_cap_reg, cold_cap_next;
    logic [RES_W-1:0] k_reg, k_next;
    logic [RES_W-1:0] total_reg, total_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [1:0]       ohit_reg, ohit_next;
    logic             oev_reg, oev_next;
    logic [KEY_W-1:0] oevkey_reg, oevkey_next;
    logic             olist_reg, olist_next;
    logic [POS_W-1:0] opos_reg, opos_next;
    logic [KEY_W-1:0] okey_reg, okey_next;
    logic             olast_reg, olast_next;

    logic [HCW-1:0]   eff_hot, cfg_eff_hot;
    logic [CCW-1:0]   eff_cold, cfg_eff_cold;
    logic [IW-1:0]    cur_count, idx_inc, idx_dec;
    logic [IW:0]      count_sum;
    logic [KEY_W-1:0] hot_rdata, cold_rdata, cur_rdata, wdata;
    logic [IW-1:0]    raddr;
    logic [IW-1:0]    waddr;
    logic             we;
    logic             out_free;

    assign eff_hot      = (int'(hot_cap_reg) > HOT_DEPTH) ? HCW'(HOT_DEPTH) : HCW'(hot_cap_reg);
    assign eff_cold     = (int'(cold_cap_reg) > COLD_DEPTH) ? CCW'(COLD_DEPTH)
                                                            : CCW'(cold_cap_reg);
    assign cfg_eff_hot  = (int'(cfg_data) > HOT_DEPTH) ? HCW'(HOT_DEPTH) : HCW'(cfg_data);
    assign cfg_eff_cold = (int'(cfg_data) > COLD_DEPTH) ? CCW'(COLD_DEPTH) : CCW'(cfg_data);

    assign cur_count = (sel_reg == LIST_COLD) ? IW'(cold_count_reg) : IW'(hot_count_reg);
    assign cur_rdata = (sel_reg == LIST_COLD) ? cold_rdata : hot_rdata;
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign count_sum = (IW + 1)'(hot_count_reg) + (IW + 1)'(cold_count_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    tslru_mem #(
        .DEPTH (HOT_DEPTH),
        .AW    (HAW)
    ) u_hot_mem (
        .clk   (clk),
        .we    (we && (sel_reg == LIST_HOT)),
        .waddr (waddr[HAW-1:0]),
        .wdata (wdata),
        .raddr (raddr[HAW-1:0]),
        .rdata (hot_rdata)
    );

    tslru_mem #(
        .DEPTH (COLD_DEPTH),
        .AW    (CAW)
    ) u_cold_mem (
        .clk   (clk),
        .we    (we && (sel_reg == LIST_COLD)),
        .waddr (waddr[CAW-1:0]),
        .wdata (wdata),
        .raddr (raddr[CAW-1:0]),
        .rdata (cold_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        newkey_next     = newkey_reg;
        aux_next        = aux_reg;
        hit_next        = hit_reg;
        ev_next         = ev_reg;
        hot_count_next  = hot_count_reg;
        cold_count_next = cold_count_reg;
        hot_cap_next    = hot_cap_reg;
        cold_cap_next   = cold_cap_reg;
        k_next          = k_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        ohit_next       = ohit_reg;
        oev_next        = oev_reg;
        oevkey_next     = oevkey_reg;
        olist_next      = olist_reg;
        opos_next       = opos_reg;
        okey_next       = okey_reg;
        olast_next      = olast_reg;
        raddr           = idx_reg;
        waddr           = idx_reg;
        wdata           = cur_rdata;
        we              = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = access_key;
                    sel_next = LIST_HOT;
                    idx_next = '0;
                    k_next   = '0;
                    hit_next = HIT_MISS;
                    ev_next  = 1'b0;
                    if (operation == OP_DUMP)
                    begin
                        total_next = (int'(count_sum) > MAX_RESULTS) ? RES_W'(MAX_RESULTS)
                                                                     : RES_W'(count_sum);
                        state_next = (count_sum == '0) ? ST_EMPTY : ST_DUMP_RD;
                    end
                    else
                    begin
                        state_next = ST_FIND_RD;
                    end
                end
            end
            ST_FIND_RD:
            begin
                if (idx_reg == cur_count)
                begin
                    if (sel_reg == LIST_HOT)
                    begin
                        sel_next = LIST_COLD;
                        idx_next = '0;
                    end
                    else
                    begin
                        state_next = ST_MISS;
                    end
                end
                else
                begin
                    state_next = ST_FIND_CMP;
                end
            end
            ST_FIND_CMP:
            begin
                if (cur_rdata == key_reg)
                begin
                    if (sel_reg == LIST_HOT)
                    begin
                        hit_next    = HIT_HOT;
                        newkey_next = key_reg;
                        phase_next  = PH_DONE;
                        state_next  = ST_SHR_RD;
                    end
                    else
                    begin
                        hit_next   = HIT_COLD;
                        state_next = ST_SHL_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_FIND_RD;
                end
            end
            ST_SHL_RD:
            begin
                raddr = idx_inc;
                if (idx_inc >= IW'(cold_count_reg))
                begin
                    cold_count_next = cold_count_reg - 1'b1;
                    state_next      = ST_POST;
                end
                else
                begin
                    state_next = ST_SHL_WR;
                end
            end
            ST_SHL_WR:
            begin
                we         = 1'b1;
                idx_next   = idx_inc;
                state_next = ST_SHL_RD;
            end
            ST_POST:
            begin
                if (hot_count_reg < eff_hot)
                begin
                    sel_next       = LIST_HOT;
                    idx_next       = IW'(hot_count_reg);
                    hot_count_next = hot_count_reg + 1'b1;
                    newkey_next    = key_reg;
                    phase_next     = PH_DONE;
                    state_next     = ST_SHR_RD;
                end
                else if (hot_count_reg != '0)
                begin
                    sel_next   = LIST_HOT;
                    idx_next   = IW'(hot_count_reg - 1'b1);
                    state_next = ST_TAIL_RD;
                end
                else
                begin
                    aux_next   = key_reg;
                    state_next = ST_DEMOTE;
                end
            end
            ST_TAIL_RD:
            begin
                state_next = ST_TAIL_GET;
            end
            ST_TAIL_GET:
            begin
                aux_next    = cur_rdata;
                newkey_next = key_reg;
                if (sel_reg == LIST_COLD)
                begin
                    ev_next    = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = PH_DEMOTE;
                end
                state_next = ST_SHR_RD;
            end
            ST_DEMOTE:
            begin
                if (cold_count_reg < eff_cold)
                begin
                    sel_next        = LIST_COLD;
                    idx_next        = IW'(cold_count_reg);
                    cold_count_next = cold_count_reg + 1'b1;
                    newkey_next     = aux_reg;
                    phase_next      = PH_DONE;
                    state_next      = ST_SHR_RD;
                end
                else
                begin
                    ev_next    = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_MISS:
            begin
                sel_next = LIST_COLD;
                if (cold_count_reg < eff_cold)
                begin
                    idx_next        = IW'(cold_count_reg);
                    cold_count_next = cold_count_reg + 1'b1;
                    newkey_next     = key_reg;
                    phase_next      = PH_DONE;
                    state_next      = ST_SHR_RD;
                end
                else if (cold_count_reg != '0)
                begin
                    idx_next   = IW'(cold_count_reg - 1'b1);
                    state_next = ST_TAIL_RD;
                end
                else
                begin
                    ev_next    = 1'b1;
                    aux_next   = key_reg;
                    state_next = ST_RESP;
                end
            end
            ST_SHR_RD:
            begin
                raddr = idx_dec;
                if (idx_reg == '0)
                begin
                    we         = 1'b1;
                    wdata      = newkey_reg;
                    state_next = (phase_reg == PH_DEMOTE) ? ST_DEMOTE : ST_RESP;
                end
                else
                begin
                    state_next = ST_SHR_WR;
                end
            end
            ST_SHR_WR:
            begin
                we         = 1'b1;
                idx_next   = idx_dec;
                state_next = ST_SHR_RD;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ACCESS;
                    ohit_next      = hit_reg;
                    oev_next       = ev_reg;
                    oevkey_next    = ev_reg ? aux_reg : '0;
                    olist_next     = LIST_HOT;
                    opos_next      = '0;
                    okey_next      = '0;
                    olast_next     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_EMPTY;
                    ohit_next      = HIT_MISS;
                    oev_next       = 1'b0;
                    oevkey_next    = '0;
                    olist_next     = LIST_HOT;
                    opos_next      = '0;
                    okey_next      = '0;
                    olast_next     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DUMP_RD:
            begin
                if ((sel_reg == LIST_HOT) && (idx_reg == IW'(hot_count_reg)))
                begin
                    sel_next = LIST_COLD;
                    idx_next = '0;
                end
                else
                begin
                    state_next = ST_DUMP_OUT;
                end
            end
            ST_DUMP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ENTRY;
                    ohit_next      = HIT_MISS;
                    oev_next       = 1'b0;
                    oevkey_next    = '0;
                    olist_next     = sel_reg;
                    opos_next      = POS_W'(idx_reg);
                    okey_next      = cur_rdata;
                    olast_next     = (k_reg + 1'b1) == total_reg;
                    if ((k_reg + 1'b1) == total_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        idx_next   = idx_inc;
                        state_next = ST_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOT_CAP:
                begin
                    hot_cap_next = cfg_data;
                    if (hot_count_reg > cfg_eff_hot)
                    begin
                        hot_count_next = cfg_eff_hot;
                    end
                end
                CFG_COLD_CAP:
                begin
                    cold_cap_next = cfg_data;
                    if (cold_count_reg > cfg_eff_cold)
                    begin
                        cold_count_next = cfg_eff_cold;
                    end
                end
                default:
                begin
                    hot_cap_next = hot_cap_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hot_count_reg  <= '0;
            cold_count_reg <= '0;
            hot_cap_reg    <= CAP_W'(16);
            cold_cap_reg   <= CAP_W'(16);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hot_count_reg  <= hot_count_next;
            cold_count_reg <= cold_count_next;
            hot_cap_reg    <= hot_cap_next;
            cold_cap_reg   <= cold_cap_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        phase_reg  <= phase_next;
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        newkey_reg <= newkey_next;
        aux_reg    <= aux_next;
        hit_reg    <= hit_next;
        ev_reg     <= ev_next;
        k_reg      <= k_next;
        total_reg  <= total_next;
        kind_reg   <= kind_next;
        ohit_reg   <= ohit_next;
        oev_reg    <= oev_next;
        oevkey_reg <= oevkey_next;
        olist_reg  <= olist_next;
        opos_reg   <= opos_next;
        okey_reg   <= okey_next;
        olast_reg  <= olast_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign hit_status    = ohit_reg;
    assign evict_valid   = oev_reg;
    assign evicted_key   = oevkey_reg;
    assign dump_list     = olist_reg;
    assign dump_position = opos_reg;
    assign dump_key      = okey_reg;
    assign last          = olast_reg;

endmodule

>>> design/tslru_mem.sv
module tslru_mem #(
    parameter int DEPTH = tslru_pkg::DEF_HOT_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [tslru_pkg::KEY_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [tslru_pkg::KEY_W-1:0] rdata
);
    import tslru_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
